// ----- sv/positional_insert_list_top_assert.svh -----
// Assertion macros shared by the positional insert list RTL.
`ifndef POSITIONAL_INSERT_LIST_TOP_ASSERT_SVH
`define POSITIONAL_INSERT_LIST_TOP_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define PIL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on every clock edge outside reset.
`define PIL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define PIL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/pil_pkg.sv -----
// Types and constants for the positional insert list.
package pil_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned VAL_W    = 32;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_FWD     = 2'd0,
    KIND_REV     = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_FULL    = 2'd3
  } kind_e;

  // Per-cell operation, chosen each cycle
  typedef enum logic [1:0] {
    OP_HOLD = 2'd0,
    OP_LOAD = 2'd1,
    OP_PREV = 2'd2,
    OP_NEXT = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic signed [POS_W-1:0] position;
    logic signed [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    kind_e                   kind;
    logic signed [VAL_W-1:0] element;
    logic                    last;
  } result_t;

endpackage

// ----- sv/pil_cell.sv -----
// One storage cell of the list chain.
module pil_cell
  import pil_pkg::*;
(
  input  logic                    clk_i,
  input  cell_op_e                op_i,
  input  logic signed [VAL_W-1:0] value_i,
  input  logic signed [VAL_W-1:0] prev_i,
  input  logic signed [VAL_W-1:0] next_i,
  output logic signed [VAL_W-1:0] data_o
);

  logic signed [VAL_W-1:0] data_q, data_d;

  // Select new contents: keep, load, or take from a neighbor
  always_comb begin
    unique case (op_i)
      OP_HOLD: data_d = data_q;
      OP_LOAD: data_d = value_i;
      OP_PREV: data_d = prev_i;
      OP_NEXT: data_d = next_i;
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ----- sv/positional_insert_list_top.sv -----
// Top level of the positional insert list: cell chain and sequencer.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-------------------------------
//  item in   | start, busy        | item_i   (position, value)
//  result    | res_valid_o strobe | result_o (kind, element, last)
//
// An error transaction (bad position or full list) keeps busy low; its result
// appears the next cycle. A valid insert shifts the chain in the accept cycle,
// then rotates the ring Capacity steps left and Capacity steps right while busy
// stays high.
// Results leave one per cycle from cell 0 or the top cell; the receiver cannot stall.
// Reset clears the count and sequencer; cell contents are undefined until written.
module positional_insert_list_top
  import pil_pkg::*;
#(
  parameter int unsigned Capacity = CAPACITY
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    res_valid_o,
  output result_t result_o
);

  `include "positional_insert_list_top_assert.svh"

  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned StepW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CmpW  = CntW + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FWD  = 2'd1;
  localparam logic [1:0] ST_REV  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [StepW-1:0] step_q, step_d;
  logic             res_valid_q, res_valid_d;
  result_t          res_q, res_d;

  logic             accept, invalid, full, ins_ok, last_step;
  logic             fwd_emit, rev_emit;
  logic [POS_W-1:0] pos_u;

  logic signed [VAL_W-1:0] cell_data [Capacity];

  // Transaction checks
  assign accept    = start && !busy;
  assign pos_u     = item_i.position;
  assign invalid   = pos_u[POS_W-1] || (pos_u > POS_W'(count_q));
  assign full      = (count_q == CntW'(Capacity));
  assign ins_ok    = accept && !invalid && !full;
  assign last_step = (step_q == StepW'(Capacity - 1));
  assign fwd_emit  = (CmpW'(step_q) < CmpW'(count_q));
  assign rev_emit  = ((CmpW'(step_q) + CmpW'(count_q)) >= CmpW'(Capacity));

  // Cell chain wired as a ring
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    localparam int unsigned PrevIdx = (i + Capacity - 1) % Capacity;
    localparam int unsigned NextIdx = (i + 1) % Capacity;
    localparam logic [POS_W-1:0] MyIdx = POS_W'(i);

    cell_op_e op;

    always_comb begin
      op = OP_HOLD;
      if (ins_ok) begin
        if (MyIdx > pos_u) op = OP_PREV;
        else if (MyIdx == pos_u) op = OP_LOAD;
      end else if (state_q == ST_FWD) begin
        op = OP_NEXT;
      end else if (state_q == ST_REV) begin
        op = OP_PREV;
      end
    end

    pil_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (op),
      .value_i (item_i.value),
      .prev_i  (cell_data[PrevIdx]),
      .next_i  (cell_data[NextIdx]),
      .data_o  (cell_data[i])
    );
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    step_d      = step_q;
    res_valid_d = 1'b0;
    res_d       = '{kind: KIND_INVALID, element: '0, last: 1'b1};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (invalid) begin
            res_valid_d = 1'b1;
          end else if (full) begin
            res_valid_d = 1'b1;
            res_d.kind  = KIND_FULL;
          end else begin
            count_d = count_q + CntW'(1);
            step_d  = '0;
            state_d = ST_FWD;
          end
        end
      end
      ST_FWD: begin
        step_d        = step_q + StepW'(1);
        res_valid_d   = fwd_emit;
        res_d.kind    = KIND_FWD;
        res_d.element = cell_data[0];
        res_d.last    = 1'b0;
        if (last_step) begin
          step_d  = '0;
          state_d = ST_REV;
        end
      end
      ST_REV: begin
        step_d        = step_q + StepW'(1);
        res_valid_d   = rev_emit;
        res_d.kind    = KIND_REV;
        res_d.element = cell_data[Capacity-1];
        res_d.last    = last_step;
        if (last_step) begin
          step_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;
  assign result_o    = res_q;

  // Checks
  `PIL_ASSERT(a_count_bound, count_q <= CntW'(Capacity), "list count above capacity")
  `PIL_ASSERT_NEXT(a_insert_busy, ins_ok, busy, "insert did not start readout")
  `PIL_ASSERT_NEXT(a_count_stable, !ins_ok, $stable(count_q), "count changed without insert")
  `PIL_ASSERT_IMPL(a_err_result, res_valid_o && result_o.kind[1],
                   result_o.last && (result_o.element == '0), "malformed error result")

endmodule
